>>> hdl/owtr_pkg.sv
package owtr_pkg;

  // Command codes carried on the input channel.
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PROBE   = 2'd1,
    OP_MEASURE = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic CFG_TICKS_PER_UNIT  = 1'b0;
  localparam logic CFG_SHORT_GAP_TICKS = 1'b1;

  localparam logic [7:0] TPU_RESET = 8'd10;
  localparam logic [3:0] GAP_RESET = 4'd2;

  // Bus sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_REL  = 4'd2,
    PH_CHK_LOW  = 4'd3,
    PH_CHK_HIGH = 4'd4,
    PH_WR_A     = 4'd5,
    PH_WR_B     = 4'd6,
    PH_RD_LOW   = 4'd7,
    PH_RD_REL   = 4'd8,
    PH_RD_WAIT  = 4'd9
  } phase_t;

  // Sequence steps of a measurement; the probe uses a step of its own.
  localparam logic [3:0] STEP_FIRST    = 4'd0;
  localparam logic [3:0] STEP_SECOND_R = 4'd3;
  localparam logic [3:0] STEP_RD_LOW   = 4'd6;
  localparam logic [3:0] STEP_RD_HIGH  = 4'd7;
  localparam logic [3:0] STEP_PROBE    = 4'd8;

  // Timing in ten-microsecond units.
  localparam logic [7:0] RESET_UNITS   = 8'd75;
  localparam logic [7:0] RELEASE_UNITS = 8'd2;
  localparam logic [7:0] SLOT_UNITS    = 8'd6;
  localparam logic [7:0] SAMPLE_UNITS  = 8'd5;
  localparam logic [6:0] POLL_LIMIT    = 7'd20;

  // Bus commands.
  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  // Command byte sent at a given write step of the measurement.
  function automatic logic [7:0] cmd_byte(input logic [3:0] step);
    logic [7:0] b;
    case (step)
      4'd1, 4'd4: b = CMD_SKIP_ROM;
      4'd2:       b = CMD_CONVERT;
      4'd5:       b = CMD_READ_PAD;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/one_wire_temperature_reader.sv
// Latency: a result is shown in the cycle after its input transfer.
// Throughput: one tick item per clock unless out_ready stalls; the whole
// sequencer update is one pass of logic from state registers back into them.
// Reset: synchronous, active-low rst_n returns the sequencer to idle, clears
// counters, readings and the absent flag, restores register defaults and
// empties the result register.
module one_wire_temperature_reader (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic               in_line_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_drive_low,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic               out_absent,
  output logic signed [16:0] out_temperature,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);
  import owtr_pkg::*;

  logic [7:0]  tpu_r;
  logic [3:0]  gap_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic [6:0]  unit_r, unit_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [16:0] reading_r, reading_nxt;
  logic        absent_r, absent_nxt;
  logic        drive_nxt, busy_nxt, done_nxt;

  logic        out_valid_r;
  logic        drive_r, busy_r, done_r;
  logic        accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers; a zero is treated as one by the timers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r <= TPU_RESET;
      gap_r <= GAP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TICKS_PER_UNIT:  tpu_r <= cfg_data;
        CFG_SHORT_GAP_TICKS: gap_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // One tick of the bus sequencer.
  always_comb begin
    phase_t     ph;
    phase_t     go_ph;
    logic       go;
    logic       adv;
    logic       chk;
    logic       chk_absent;
    logic [7:0] tc;
    logic [6:0] uc;
    logic [7:0] tpu_eff;
    logic [3:0] gap_eff;
    logic [8:0] tc_inc;
    logic [7:0] unit_inc;
    logic       tick_wrap;
    logic       gap_wrap;
    logic       want_high;
    logic       bit_done;
    logic [7:0] sb_new;
    logic [15:0] word;

    ph          = phase_r;
    tc          = tick_r;
    uc          = unit_r;
    bit_nxt     = bit_r;
    step_nxt    = step_r;
    shift_nxt   = shift_r;
    low_nxt     = low_r;
    reading_nxt = reading_r;
    absent_nxt  = absent_r;
    done_nxt    = 1'b0;
    go          = 1'b0;
    go_ph       = PH_IDLE;
    adv         = 1'b0;
    chk         = 1'b0;
    chk_absent  = 1'b0;
    bit_done    = 1'b0;
    sb_new      = shift_r;
    word        = 16'h0000;

    // A command starts a sequence only from idle.
    if (ph == PH_IDLE && (in_op == OP_PROBE || in_op == OP_MEASURE)) begin
      step_nxt = (in_op == OP_PROBE) ? STEP_PROBE : STEP_FIRST;
      bit_nxt  = 3'd0;
      ph       = PH_RST_LOW;
      tc       = 8'd0;
      uc       = 7'd0;
    end

    busy_nxt  = (ph != PH_IDLE);
    drive_nxt = (ph == PH_RST_LOW) || (ph == PH_WR_A) || (ph == PH_RD_LOW);

    // Shared timer arithmetic.
    tpu_eff   = (tpu_r == 8'd0) ? 8'd1 : tpu_r;
    gap_eff   = (gap_r == 4'd0) ? 4'd1 : gap_r;
    tc_inc    = {1'b0, tc} + 9'd1;
    unit_inc  = {1'b0, uc} + 8'd1;
    tick_wrap = tc_inc >= {1'b0, tpu_eff};
    gap_wrap  = tc_inc >= {5'b0, gap_eff};
    want_high = (ph == PH_CHK_HIGH);

    // Default timer advance for a unit-timed phase.
    tick_nxt = tick_wrap ? 8'd0 : tc_inc[7:0];
    unit_nxt = tick_wrap ? unit_inc[6:0] : uc;

    case (ph)
      PH_IDLE: begin
        tick_nxt = tc;
        unit_nxt = uc;
      end
      PH_RST_LOW: begin
        if (tick_wrap && unit_inc >= RESET_UNITS) begin
          go = 1'b1; go_ph = PH_RST_REL;
        end
      end
      PH_RST_REL: begin
        if (tick_wrap && unit_inc >= RELEASE_UNITS) begin
          go = 1'b1; go_ph = PH_CHK_LOW;
        end
      end
      PH_CHK_LOW, PH_CHK_HIGH: begin
        // The line is polled on the first tick of each unit.
        if (tc == 8'd0 && uc >= POLL_LIMIT) begin
          chk = 1'b1; chk_absent = 1'b1;
        end else if (tc == 8'd0 && in_line_level == want_high) begin
          if (want_high) begin
            chk = 1'b1;
          end else begin
            go = 1'b1; go_ph = PH_CHK_HIGH;
          end
        end
      end
      PH_WR_A: begin
        // A short pulse counts plain ticks and leaves the unit count alone.
        if (shift_r[0]) begin
          tick_nxt = tc_inc[7:0];
          unit_nxt = uc;
        end
        if (shift_r[0] ? gap_wrap : (tick_wrap && unit_inc >= SLOT_UNITS)) begin
          go = 1'b1; go_ph = PH_WR_B;
        end
      end
      PH_WR_B: begin
        if (!shift_r[0]) begin
          tick_nxt = tc_inc[7:0];
          unit_nxt = uc;
        end
        if (shift_r[0] ? (tick_wrap && unit_inc >= SLOT_UNITS) : gap_wrap) begin
          shift_nxt = {1'b0, shift_r[7:1]};
          bit_done  = 1'b1;
          go_ph     = PH_WR_A;
        end
      end
      PH_RD_LOW: begin
        tick_nxt = tc_inc[7:0];
        unit_nxt = uc;
        if (gap_wrap) begin
          go = 1'b1; go_ph = PH_RD_REL;
        end
      end
      PH_RD_REL: begin
        tick_nxt = tc_inc[7:0];
        unit_nxt = uc;
        if (gap_wrap) begin
          go = 1'b1; go_ph = PH_RD_WAIT;
        end
      end
      PH_RD_WAIT: begin
        // Sample on the first tick of the wait, LSB first.
        if (tc == 8'd0 && uc == 7'd0) begin
          sb_new = {in_line_level, shift_r[7:1]};
        end
        shift_nxt = sb_new;
        if (tick_wrap && unit_inc >= SAMPLE_UNITS) begin
          if (bit_r == 3'd7) begin
            if (step_r == STEP_RD_LOW) begin
              low_nxt = sb_new;
            end else begin
              word = {sb_new, low_r};
              reading_nxt = (word[15:11] == 5'b11111) ? {1'b1, word} : {1'b0, word};
            end
          end
          bit_done = 1'b1;
          go_ph    = PH_RD_LOW;
        end
      end
      default: begin
        go = 1'b1; go_ph = PH_IDLE; done_nxt = 1'b1;
      end
    endcase

    // End of a bit: next bit or next step.
    if (bit_done) begin
      if (bit_r == 3'd7) begin
        adv = 1'b1;
      end else begin
        bit_nxt = bit_r + 3'd1;
        go      = 1'b1;
      end
    end

    // Presence check finished.
    if (chk) begin
      if (step_r == STEP_PROBE) begin
        absent_nxt = chk_absent;
        go = 1'b1; go_ph = PH_IDLE; done_nxt = 1'b1;
      end else begin
        adv = 1'b1;
      end
    end

    // Move on to the next step of the measurement.
    if (adv) begin
      go = 1'b1;
      if (step_r >= STEP_RD_HIGH) begin
        go_ph = PH_IDLE; done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 4'd1;
        bit_nxt  = 3'd0;
        if (step_nxt == STEP_FIRST || step_nxt == STEP_SECOND_R) begin
          go_ph = PH_RST_LOW;
        end else if (step_nxt == STEP_RD_LOW || step_nxt == STEP_RD_HIGH) begin
          shift_nxt = 8'h00;
          go_ph     = PH_RD_LOW;
        end else begin
          shift_nxt = cmd_byte(step_nxt);
          go_ph     = PH_WR_A;
        end
      end
    end

    // Entering a phase restarts its timer.
    phase_nxt = ph;
    if (go) begin
      phase_nxt = go_ph;
      tick_nxt  = 8'd0;
      unit_nxt  = 7'd0;
    end
  end

  // Sequencer state, updated on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= 8'd0;
      unit_r    <= 7'd0;
      bit_r     <= 3'd0;
      step_r    <= 4'd0;
      shift_r   <= 8'd0;
      low_r     <= 8'd0;
      reading_r <= 17'd0;
      absent_r  <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      unit_r    <= unit_nxt;
      bit_r     <= bit_nxt;
      step_r    <= step_nxt;
      shift_r   <= shift_nxt;
      low_r     <= low_nxt;
      reading_r <= reading_nxt;
      absent_r  <= absent_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive_r <= drive_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_low   = drive_r;
  assign out_busy_res    = busy_r;
  assign out_done_res    = done_r;
  assign out_absent      = absent_r;
  assign out_temperature = reading_r;

endmodule

>>> hdl/owtr_checker.sv
module owtr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_drive_low,
  input logic               out_busy_res,
  input logic               out_done_res,
  input logic               out_absent,
  input logic signed [16:0] out_temperature
);

  // A stalled result holds its value until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_temperature)
      && $stable(out_done_res) && $stable(out_absent) && $stable(out_drive_low))
    else $error("result changed while stalled");

  // Input is only held back while a result is waiting.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // Finishing and driving the line happen only inside a sequence.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_done_res || out_drive_low) |-> out_busy_res)
    else $error("done or drive outside a sequence");

  // A negative reading always has its top five word bits set.
  a_temp_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_temperature[16] |-> (out_temperature[15:11] == 5'b11111))
    else $error("malformed negative reading");

  // The result register is empty after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind one_wire_temperature_reader owtr_checker u_owtr_checker (.*);
